// File: rtl/mtid_pkg.sv
`timescale 1ns / 1ps

package mtid_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_SEED_LOW  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SEED_HIGH = 1'b1;

  // Fixed identifier layout pieces.
  localparam logic [63:0] GOLDEN_WORD    = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [3:0]  VERSION_NIBBLE = 4'h7;
  localparam logic [1:0]  VARIANT_CODE   = 2'b10;

  // Time limits.
  localparam logic [63:0] MAX_SEC    = 64'd281474976710;
  localparam logic [31:0] NANO_LIMIT = 32'd1000000000;

  // Reciprocal of 15625 scaled by 2^38, rounded up. Exact for 24-bit dividends.
  localparam logic [48:0] NANO_DIV_MUL = 49'd17592187;

  typedef enum logic [1:0] {
    ACT_MONO      = 2'd0,
    ACT_SEC_NANOS = 2'd1,
    ACT_SEC       = 2'd2,
    ACT_NANOS     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_NANOS = 2'd1,
    STATUS_BAD_TIME  = 2'd2
  } status_e;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } gen_t;

  // Generator advance request: one or two steps.
  typedef struct packed {
    logic step;
    logic double;
  } rng_ctl_t;

  // Monotonic mode decision.
  typedef struct packed {
    logic [48:0] ms;
    logic [41:0] ctr;
    logic        second;
  } mono_t;

  // Explicit time decode.
  typedef struct packed {
    status_e     status;
    logic [48:0] ms;
  } expl_t;

  // One xoroshiro128+ state transition.
  function automatic gen_t gen_step(gen_t s);
    gen_t        n;
    logic [63:0] x;
    x   = s.b ^ s.a;
    n.a = {s.a[8:0], s.a[63:9]} ^ x ^ (x << 14);
    n.b = {x[27:0], x[63:28]};
    return n;
  endfunction

endpackage

// File: rtl/mtid_rng.sv
`timescale 1ns / 1ps

module mtid_rng
  import mtid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  rng_ctl_t           ctl_i,
  output logic [63:0]        draw1_o,
  output logic [63:0]        draw2_o
);

  logic [63:0] seed_low_q, seed_low_d;
  logic [63:0] seed_high_q, seed_high_d;
  gen_t        gen_q, gen_d;
  gen_t        gen1, gen2;

  // Two-step lookahead of the generator.
  always_comb begin
    gen1    = gen_step(gen_q);
    gen2    = gen_step(gen1);
    draw1_o = gen_q.a + gen_q.b;
    draw2_o = gen1.a + gen1.b;
  end

  // Seed writes reload the generator; otherwise advance as requested.
  always_comb begin
    seed_low_d  = seed_low_q;
    seed_high_d = seed_high_q;
    gen_d       = gen_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEED_LOW:  seed_low_d  = cfg_data_i;
        CFG_SEED_HIGH: seed_high_d = cfg_data_i;
        default: ;
      endcase
      gen_d.a = seed_low_d;
      gen_d.b = ((seed_low_d | seed_high_d) == 64'd0) ? GOLDEN_WORD : seed_high_d;
    end else if (ctl_i.double) begin
      gen_d = gen2;
    end else if (ctl_i.step) begin
      gen_d = gen1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_low_q  <= '0;
      seed_high_q <= '0;
      gen_q.a     <= '0;
      gen_q.b     <= GOLDEN_WORD;
    end else begin
      seed_low_q  <= seed_low_d;
      seed_high_q <= seed_high_d;
      gen_q       <= gen_d;
    end
  end

endmodule

// File: rtl/mtid_mono.sv
`timescale 1ns / 1ps

module mtid_mono
  import mtid_pkg::*;
(
  input  logic [48:0] last_ms_i,
  input  logic [41:0] counter_i,
  input  logic [47:0] now_ms_i,
  input  logic [63:0] draw1_i,
  input  logic [63:0] draw2_i,
  output mono_t       mono_o
);

  logic [4:0]  step;
  logic [42:0] ctr_sum;
  logic        now_later;

  // Random step of 1 to 16 and the counter sum with its carry.
  always_comb begin
    step      = {1'b0, draw1_i[35:32]} + 5'd1;
    ctr_sum   = {1'b0, counter_i} + {38'd0, step};
    now_later = {1'b0, now_ms_i} > last_ms_i;
  end

  // A later time or a counter overflow reloads the counter from a second draw.
  always_comb begin
    if (now_later) begin
      mono_o.ms     = {1'b0, now_ms_i};
      mono_o.ctr    = {1'b0, draw2_i[40:0]};
      mono_o.second = 1'b1;
    end else if (ctr_sum[42]) begin
      mono_o.ms     = last_ms_i + 49'd1;
      mono_o.ctr    = {1'b0, draw2_i[40:0]};
      mono_o.second = 1'b1;
    end else begin
      mono_o.ms     = last_ms_i;
      mono_o.ctr    = ctr_sum[41:0];
      mono_o.second = 1'b0;
    end
  end

endmodule

// File: rtl/mtid_explicit.sv
`timescale 1ns / 1ps

module mtid_explicit
  import mtid_pkg::*;
(
  input  action_e     action_i,
  input  logic [47:0] now_ms_i,
  input  logic [63:0] seconds_i,
  input  logic [31:0] nanos_i,
  output expl_t       expl_o
);

  logic [48:0] sec49;
  logic [48:0] sec_ms;
  logic [48:0] div_prod;
  logic [9:0]  nano_ms;
  logic [48:0] sum_ms;
  logic        nanos_bad;
  logic        sec_bad;

  // Seconds times 1000 as shifts and subtracts; nanos / 1e6 by reciprocal.
  always_comb begin
    sec49    = {10'd0, seconds_i[38:0]};
    sec_ms   = (sec49 << 10) - (sec49 << 4) - (sec49 << 3);
    div_prod = {25'd0, nanos_i[29:6]} * NANO_DIV_MUL;
    nano_ms  = div_prod[47:38];
    sum_ms   = sec_ms + ((action_i == ACT_SEC_NANOS) ? {39'd0, nano_ms} : 49'd0);
    nanos_bad = ((action_i == ACT_SEC_NANOS) || (action_i == ACT_NANOS)) &&
                (nanos_i >= NANO_LIMIT);
    sec_bad   = (seconds_i > MAX_SEC) || sum_ms[48];
  end

  // Bad nanos takes precedence over a bad time.
  always_comb begin
    expl_o.ms     = (action_i == ACT_NANOS) ? {1'b0, now_ms_i} : sum_ms;
    expl_o.status = STATUS_OK;
    if (nanos_bad) begin
      expl_o.status = STATUS_BAD_NANOS;
    end else if ((action_i != ACT_NANOS) && sec_bad) begin
      expl_o.status = STATUS_BAD_TIME;
    end
  end

endmodule

// File: rtl/monotonic_time_ordered_id_generator.sv
`timescale 1ns / 1ps
// An accepted item sits in the input register, then its result is registered.
// One item per cycle unless the output stalls; the generator state and the
// ms and counter registers update in the same cycle as the result register.
// Reset: zero seeds, so the generator holds zero and the golden word, and the
// last time and counter are zero. No clearing pass is needed.
module monotonic_time_ordered_id_generator
  import mtid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [47:0]        now_ms_i,
  input  logic [63:0]        seconds_i,
  input  logic [31:0]        nanos_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        id_high_o,
  output logic [63:0]        id_low_o,
  output logic [1:0]         status_o
);

  logic        in_valid_q;
  action_e     action_q;
  logic [47:0] now_ms_q;
  logic [63:0] seconds_q;
  logic [31:0] nanos_q;

  logic        out_valid_q;
  logic [63:0] id_high_q, id_high_d;
  logic [63:0] id_low_q, id_low_d;
  status_e     status_q, status_d;

  logic [48:0] last_ms_q, last_ms_d;
  logic [41:0] counter_q, counter_d;

  logic        fire;
  logic [63:0] draw1;
  logic [63:0] draw2;
  rng_ctl_t    rng_ctl;
  mono_t       mono;
  expl_t       expl;

  // Handshake: the input register refills when it is empty or its item fires.
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign id_high_o   = id_high_q;
  assign id_low_o    = id_low_q;
  assign status_o    = status_q;

  mtid_rng u_rng (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (rng_ctl),
    .draw1_o     (draw1),
    .draw2_o     (draw2)
  );

  mtid_mono u_mono (
    .last_ms_i (last_ms_q),
    .counter_i (counter_q),
    .now_ms_i  (now_ms_q),
    .draw1_i   (draw1),
    .draw2_i   (draw2),
    .mono_o    (mono)
  );

  mtid_explicit u_explicit (
    .action_i  (action_q),
    .now_ms_i  (now_ms_q),
    .seconds_i (seconds_q),
    .nanos_i   (nanos_q),
    .expl_o    (expl)
  );

  // Result assembly and state update for the item in the input register.
  always_comb begin
    id_high_d      = '0;
    id_low_d       = '0;
    status_d       = STATUS_OK;
    last_ms_d      = last_ms_q;
    counter_d      = counter_q;
    rng_ctl.step   = 1'b0;
    rng_ctl.double = 1'b0;
    unique case (action_q)
      ACT_MONO: begin
        id_high_d      = {mono.ms[47:0], VERSION_NIBBLE, mono.ctr[41:30]};
        id_low_d       = {VARIANT_CODE, mono.ctr[29:0], draw1[31:0]};
        last_ms_d      = mono.ms;
        counter_d      = mono.ctr;
        rng_ctl.step   = 1'b1;
        rng_ctl.double = mono.second;
      end
      ACT_SEC_NANOS: begin
        status_d = expl.status;
        if (expl.status == STATUS_OK) begin
          id_high_d    = {expl.ms[47:0], VERSION_NIBBLE, nanos_q[11:0]};
          id_low_d     = {VARIANT_CODE, draw1[61:0]};
          rng_ctl.step = 1'b1;
        end
      end
      default: begin
        status_d = expl.status;
        if (expl.status == STATUS_OK) begin
          id_high_d      = {expl.ms[47:0], VERSION_NIBBLE, 1'b0, draw1[40:30]};
          id_low_d       = {VARIANT_CODE, draw1[29:0], draw2[31:0]};
          rng_ctl.double = 1'b1;
        end
      end
    endcase
    if (!fire) begin
      last_ms_d      = last_ms_q;
      counter_d      = counter_q;
      rng_ctl.step   = 1'b0;
      rng_ctl.double = 1'b0;
    end
    // Seed writes clear the time and counter.
    if (cfg_we_i) begin
      last_ms_d = '0;
      counter_d = '0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_ms_q   <= '0;
      counter_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      last_ms_q <= last_ms_d;
      counter_q <= counter_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q  <= action_e'(action_i);
      now_ms_q  <= now_ms_i;
      seconds_q <= seconds_i;
      nanos_q   <= nanos_i;
    end
    if (fire) begin
      id_high_q <= id_high_d;
      id_low_q  <= id_low_d;
      status_q  <= status_d;
    end
  end

  // An error result carries all-zero identifier words.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_q != STATUS_OK) |-> (id_high_o == 64'd0) && (id_low_o == 64'd0))
    else $error("error result with nonzero identifier");

  // A good result carries the version and variant codes.
  a_layout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_q == STATUS_OK) |->
      (id_high_o[15:12] == VERSION_NIBBLE) && (id_low_o[63:62] == VARIANT_CODE))
    else $error("good result without version or variant bits");

  // A held item must not be overwritten while the result is stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o && !fire)
    else $error("input register taken while the result is stalled");

  // The generator never advances without a result being produced.
  a_rng_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rng_ctl.step || rng_ctl.double) |-> fire)
    else $error("generator advanced without an item");

endmodule
